### rtl/core/see_pkg.sv
// Package for the stack expression evaluator: sizes, codes and state types.
// Used by the top level and the checker under rtl/core; depends on nothing.
package see_pkg;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OPERAND_W = 31;
  localparam int OUT_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_APPLY  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIVZERO   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_NEGEXP    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_ITER,
    S_DONE,
    S_OUT
  } state_t;
endpackage

### rtl/core/see_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module see_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/stack_expression_evaluator.sv
// Top level of the stack expression evaluator.
// Depends on see_pkg and see_ram.
// Each item is a token: push, apply an operator or finish. Add, subtract and multiply take
// longer than push and finish, as the two top entries are read one after the other from the
// single-read-port stack memory. Divide and modulo then run a restoring divider one quotient
// bit a cycle; power runs square-and-multiply over the exponent bits, two multiplies a bit.
// One token is worked on at a time; the next is taken once the result is moved into the
// output register.
module stack_expression_evaluator #(
  parameter int STACK_DEPTH = see_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = see_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[1:0], operand[32:2], op_code[35:33], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // value[31:0], status[34:32], depth[41:35], zero
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(2 * DATA_WIDTH + 1);
  localparam int XW = (DATA_WIDTH > see_pkg::OPERAND_W) ? DATA_WIDTH : see_pkg::OPERAND_W;

  see_pkg::state_t state_r, state_nxt;
  logic [1:0]            cmd_r;
  logic [2:0]            op_r;
  logic [DATA_WIDTH-1:0] opnd_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] a_r, b_r, res_r, rem_r, quo_r, base_r, ex_r;
  logic [IW-1:0]         it_r;
  logic                  step_r;
  logic                  rd_phase_r;
  logic [2:0]            st_r;
  logic                  wr_r;
  logic [DATA_WIDTH-1:0] ram_q;
  logic [AW-1:0]         raddr;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [31:0]           val_w;
  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH:0]   trial;
  logic [2*DATA_WIDTH-1:0] prod_rb, prod_bb;
  logic [XW-1:0]         opnd_x;
  logic [2:0]            calc_st;
  logic                  calc_wr;
  logic [DATA_WIDTH-1:0] calc_res;

  assign opnd_x = XW'(in_tdata[32:2]);
  assign mag_a = a_r[DATA_WIDTH-1] ? -a_r : a_r;
  assign mag_b = b_r[DATA_WIDTH-1] ? -b_r : b_r;
  assign trial = {rem_r, quo_r[DATA_WIDTH-1]} - {1'b0, mag_b};
  assign prod_rb = res_r * base_r;
  assign prod_bb = base_r * base_r;

  see_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(ram_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      see_pkg::S_IDLE: if (in_tvalid && in_tready) state_nxt = see_pkg::S_READ;
      see_pkg::S_READ: if (rd_phase_r || cmd_r != see_pkg::CMD_APPLY) state_nxt = see_pkg::S_CALC;
      see_pkg::S_CALC: begin
        if (cmd_r == see_pkg::CMD_APPLY && cnt_r >= CW'(2) &&
            (op_r == see_pkg::OP_DIV || op_r == see_pkg::OP_MOD || op_r == see_pkg::OP_POW) &&
            b_r != '0 && !(op_r == see_pkg::OP_POW && b_r[DATA_WIDTH-1])) begin
          state_nxt = see_pkg::S_ITER;
        end else begin
          state_nxt = see_pkg::S_DONE;
        end
      end
      see_pkg::S_ITER: if (it_r == '0) state_nxt = see_pkg::S_DONE;
      see_pkg::S_DONE: state_nxt = see_pkg::S_OUT;
      see_pkg::S_OUT: if (!out_tvalid || out_tready) state_nxt = see_pkg::S_IDLE;
      default: state_nxt = see_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == see_pkg::S_IDLE);
    raddr = AW'(cnt_r - CW'(1));
    if (state_r == see_pkg::S_READ && !rd_phase_r) raddr = AW'(cnt_r - CW'(2));
    we = (state_r == see_pkg::S_DONE) && wr_r;
    waddr = (cmd_r == see_pkg::CMD_PUSH) ? AW'(cnt_r) : AW'(cnt_r - CW'(2));
    wdata = res_r;
    cnt_nxt = cnt_r;
    if (we) cnt_nxt = (cmd_r == see_pkg::CMD_PUSH) ? cnt_r + CW'(1) : cnt_r - CW'(1);
    if (state_r == see_pkg::S_DONE && cmd_r == see_pkg::CMD_FINISH && st_r == see_pkg::ST_OK)
      cnt_nxt = '0;
    val_w = (wr_r || cmd_r == see_pkg::CMD_FINISH) && st_r == see_pkg::ST_OK ?
            32'(signed'(res_r)) : '0;
  end

  always_comb begin
    calc_st = see_pkg::ST_OK;
    calc_wr = 1'b0;
    calc_res = '0;
    unique case (cmd_r)
      see_pkg::CMD_PUSH: begin
        if (cnt_r >= CW'(STACK_DEPTH)) calc_st = see_pkg::ST_OVERFLOW;
        else begin
          calc_wr = 1'b1;
          calc_res = opnd_r;
        end
      end
      see_pkg::CMD_APPLY: begin
        if (cnt_r < CW'(2)) calc_st = see_pkg::ST_UNDERFLOW;
        else begin
          case (op_r) inside
            see_pkg::OP_ADD: begin calc_res = a_r + b_r; calc_wr = 1'b1; end
            see_pkg::OP_SUB: begin calc_res = a_r - b_r; calc_wr = 1'b1; end
            see_pkg::OP_MUL: begin calc_res = DATA_WIDTH'(a_r * b_r); calc_wr = 1'b1; end
            see_pkg::OP_DIV, see_pkg::OP_MOD: begin
              if (b_r == '0) calc_st = see_pkg::ST_DIVZERO;
              else calc_wr = 1'b1;
            end
            see_pkg::OP_POW: begin
              if (b_r[DATA_WIDTH-1]) calc_st = see_pkg::ST_NEGEXP;
              else begin
                calc_wr = 1'b1;
                calc_res = DATA_WIDTH'(1);
              end
            end
            default: ;
          endcase
        end
      end
      see_pkg::CMD_FINISH: begin
        if (cnt_r == '0) calc_st = see_pkg::ST_EMPTY;
        else calc_res = a_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= see_pkg::S_IDLE;
      cnt_r <= '0;
      out_tvalid <= 1'b0;
      rd_phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      if (state_r == see_pkg::S_OUT && (!out_tvalid || out_tready)) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (state_r == see_pkg::S_READ) rd_phase_r <= ~rd_phase_r & (cmd_r == see_pkg::CMD_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      see_pkg::S_IDLE: begin
        cmd_r <= in_tdata[1:0];
        opnd_r <= DATA_WIDTH'(opnd_x);
        op_r <= in_tdata[35:33];
      end
      see_pkg::S_READ: begin
        if (rd_phase_r) b_r <= ram_q;
      end
      see_pkg::S_CALC: begin
        st_r <= calc_st;
        wr_r <= calc_wr;
        res_r <= calc_res;
        quo_r <= mag_a;
        rem_r <= '0;
        base_r <= a_r;
        ex_r <= b_r;
        it_r <= (op_r == see_pkg::OP_POW) ? IW'(2 * DATA_WIDTH - 1) : IW'(DATA_WIDTH - 1);
        step_r <= 1'b0;
      end
      see_pkg::S_ITER: begin
        it_r <= it_r - IW'(1);
        if (op_r == see_pkg::OP_POW) begin
          step_r <= ~step_r;
          if (!step_r) begin
            if (ex_r[0]) res_r <= prod_rb[DATA_WIDTH-1:0];
          end else begin
            base_r <= prod_bb[DATA_WIDTH-1:0];
            ex_r <= ex_r >> 1;
          end
        end else begin
          quo_r <= {quo_r[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
          rem_r <= trial[DATA_WIDTH] ? {rem_r[DATA_WIDTH-2:0], quo_r[DATA_WIDTH-1]}
                                     : trial[DATA_WIDTH-1:0];
        end
        if (it_r == '0 && op_r != see_pkg::OP_POW) begin
          if (op_r == see_pkg::OP_DIV) begin
            res_r <= (a_r[DATA_WIDTH-1] != b_r[DATA_WIDTH-1]) ?
                     -{quo_r[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]} :
                     {quo_r[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
          end else begin
            res_r <= a_r[DATA_WIDTH-1] ?
                     -(trial[DATA_WIDTH] ? {rem_r[DATA_WIDTH-2:0], quo_r[DATA_WIDTH-1]}
                                         : trial[DATA_WIDTH-1:0]) :
                     (trial[DATA_WIDTH] ? {rem_r[DATA_WIDTH-2:0], quo_r[DATA_WIDTH-1]}
                                        : trial[DATA_WIDTH-1:0]);
          end
        end
      end
      see_pkg::S_OUT: begin
        if (!out_tvalid || out_tready)
          out_tdata <= {6'd0, 7'(cnt_r), st_r, val_w};
      end
      default: ;
    endcase
    if (state_r == see_pkg::S_READ && !rd_phase_r) a_r <= ram_q;
  end
endmodule

### rtl/core/see_checker.sv
// Port-level checker for the stack expression evaluator, bound to the top level.
// Depends on see_pkg and stack_expression_evaluator.
module see_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out held");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("one token at a time");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] != see_pkg::ST_OK |-> out_tdata[31:0] == 32'd0)
    else $error("err value");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] == see_pkg::ST_EMPTY |-> out_tdata[41:35] == 7'd0)
    else $error("empty");
endmodule

bind stack_expression_evaluator see_checker u_see_checker (.*);
